// ----- rtl/ctrt_pkg.sv -----
// Shared types and codes for the chunked transfer reassembly tracker.
package ctrt_pkg;

    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};

    typedef logic [2:0] status_t;

    localparam status_t ST_STORED     = 3'd0;
    localparam status_t ST_RETRY      = 3'd1;
    localparam status_t ST_STARTED    = 3'd2;
    localparam status_t ST_PARSE_FAIL = 3'd3;
    localparam status_t ST_NO_RANGE   = 3'd4;
    localparam status_t ST_BOUNDS     = 3'd5;
    localparam status_t ST_SHORT      = 3'd6;
    localparam status_t ST_BAD_COUNT  = 3'd7;

    typedef struct packed {
        logic        parse_ok;
        logic [15:0] chunk_index;
        logic [15:0] payload_length;
        logic [31:0] path_key;
        logic [15:0] vertex_total;
        logic [15:0] turn_total;
        logic [15:0] total_chunks;
        logic [23:0] image_bytes;
    } item_t;

    typedef struct packed {
        logic [31:0] path_key;
        logic [15:0] vertex_total;
        logic [15:0] turn_total;
        logic [15:0] total_chunks;
        logic [23:0] image_bytes;
    } held_t;

    typedef struct packed {
        status_t     status;
        logic        accepted;
        logic        write_enable;
        logic        restart;
        logic        arrive_new;
        logic        done;
        logic [15:0] tally_inc;
    } check_t;

endpackage

// ----- rtl/ctrt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ctrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ctrt_check.sv -----
// Chunk classification: manifest retry/restart, range, bounds and length checks.
module ctrt_check #(
    parameter int MAX_CHUNKS = 1024,
    parameter int CHUNK_PAYLOAD_BYTES = 240
) (
    input  ctrt_pkg::item_t item,
    input  logic [16+$clog2(CHUNK_PAYLOAD_BYTES+1)-1:0] offset,
    input  logic            held_valid,
    input  ctrt_pkg::held_t held,
    input  logic [15:0]     tally,
    input  logic            hit,
    output ctrt_pkg::check_t res
);

    localparam int OFF_W = 16 + $clog2(CHUNK_PAYLOAD_BYTES + 1);
    localparam int CMP_W = ((OFF_W > 24) ? OFF_W : 24) + 1;
    localparam logic [15:0] MAX_TOTAL = 16'(MAX_CHUNKS);
    localparam logic [15:0] FULL_LEN = 16'(CHUNK_PAYLOAD_BYTES);

    logic             is_manifest;
    logic             match;
    logic             bad_total;
    logic             range_bad;
    logic             last;
    logic             oob;
    logic             short_len;
    logic [CMP_W-1:0] off_x;
    logic [CMP_W-1:0] end_x;
    logic [CMP_W-1:0] size_x;

    assign is_manifest = (item.chunk_index == 16'd0);
    assign match = held_valid && (item.path_key == held.path_key)
                   && (item.vertex_total == held.vertex_total)
                   && (item.turn_total == held.turn_total);
    assign bad_total = (item.total_chunks == 16'd0) || (item.total_chunks > MAX_TOTAL);
    assign range_bad = !held_valid || (item.chunk_index >= held.total_chunks);
    assign last = (item.chunk_index == (held.total_chunks - 16'd1));

    assign off_x = CMP_W'(offset);
    assign end_x = off_x + CMP_W'(item.payload_length);
    assign size_x = CMP_W'(held.image_bytes);
    assign oob = (off_x >= size_x) || (end_x > size_x);
    assign short_len = !last && (item.payload_length != FULL_LEN);

    always_comb
    begin
        res = '0;
        res.tally_inc = tally;
        if (!item.parse_ok)
        begin
            res.status = ctrt_pkg::ST_PARSE_FAIL;
        end
        else if (is_manifest)
        begin
            if (match)
            begin
                res.status = ctrt_pkg::ST_RETRY;
                res.accepted = 1'b1;
            end
            else if (bad_total)
            begin
                res.status = ctrt_pkg::ST_BAD_COUNT;
            end
            else
            begin
                res.status = ctrt_pkg::ST_STARTED;
                res.accepted = 1'b1;
                res.restart = 1'b1;
            end
        end
        else if (range_bad)
        begin
            res.status = ctrt_pkg::ST_NO_RANGE;
        end
        else if (oob)
        begin
            res.status = ctrt_pkg::ST_BOUNDS;
        end
        else if (short_len)
        begin
            res.status = ctrt_pkg::ST_SHORT;
        end
        else
        begin
            res.status = ctrt_pkg::ST_STORED;
            res.accepted = 1'b1;
            res.write_enable = 1'b1;
            res.arrive_new = !hit;
            res.tally_inc = tally + (hit ? 16'd0 : 16'd1);
            res.done = (res.tally_inc == held.total_chunks);
        end
    end

endmodule

// ----- rtl/chunked_transfer_reassembly_tracker_core.sv -----
// Top level of the chunked transfer reassembly tracker.
//
// Tracks a chunked transfer: chunk 0 carries the manifest, payload chunks
// are range/bounds/length checked and their arrival is recorded in an
// arrival memory of MAX_CHUNKS entries. Each entry holds an epoch tag; an
// entry counts as arrived only if its tag equals the current epoch, so a new
// transfer or a completion clears the whole bitmap by bumping the epoch.
// Each chunk is first captured, with its byte offset computed and its
// arrival entry read, then classified, with the entry written back.
// The block then takes the next chunk; the result waits in an output
// register, so a stalled result blocks the next chunk only once its own
// result is ready. After reset, and each time the epoch counter wraps
// (every 255 transfer starts or completions), the tag memory is swept to
// zero at one entry per cycle with s_tready low, over all MAX_CHUNKS entries.
module chunked_transfer_reassembly_tracker_core #(
    parameter int MAX_CHUNKS = 1024,
    parameter int CHUNK_PAYLOAD_BYTES = 240
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // chunk_index[15:0], payload_length[31:16], path_key[63:32],
    // vertex_total[79:64], turn_total[95:80], total_chunks[111:96],
    // image_bytes[135:112]
    input  logic [135:0] s_tdata,
    // parse_ok[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // accepted[0], write_enable[1], write_offset[25:2],
    // transfer_complete[26], arrived_count[42:27], zero pad
    output logic [47:0]  m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser
);

    localparam int AW = $clog2(MAX_CHUNKS);
    localparam int OFF_W = 16 + $clog2(CHUNK_PAYLOAD_BYTES + 1);
    localparam int EW = ctrt_pkg::EPOCH_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CHUNKS - 1);

    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_LOOKUP = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [EW-1:0] epoch_reg, epoch_next;
    logic          held_valid_reg, held_valid_next;
    ctrt_pkg::held_t held_reg, held_next;
    logic [15:0]   tally_reg, tally_next;

    // captured chunk and its precomputed byte offset
    ctrt_pkg::item_t item_reg;
    logic [OFF_W-1:0] offset_reg;

    // output register
    logic          m_tvalid_reg, m_tvalid_next;
    ctrt_pkg::status_t out_status_reg;
    logic          out_accepted_reg;
    logic          out_we_reg;
    logic [23:0]   out_offset_reg;
    logic          out_done_reg;
    logic [15:0]   out_count_reg;

    ctrt_pkg::item_t  in_item;
    ctrt_pkg::check_t chk;
    logic             accept;
    logic             out_free;
    logic             finish;
    logic             bump;
    logic             hit;
    logic [EW-1:0]    tag_rdata;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [EW-1:0]    ram_wdata;
    logic [15:0]      count;

    assign in_item.parse_ok       = s_tuser;
    assign in_item.chunk_index    = s_tdata[15:0];
    assign in_item.payload_length = s_tdata[31:16];
    assign in_item.path_key       = s_tdata[63:32];
    assign in_item.vertex_total   = s_tdata[79:64];
    assign in_item.turn_total     = s_tdata[95:80];
    assign in_item.total_chunks   = s_tdata[111:96];
    assign in_item.image_bytes    = s_tdata[135:112];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == S_LOOKUP) && out_free;
    assign hit      = (tag_rdata == epoch_reg);

    ctrt_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_CHUNKS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_item.chunk_index[AW-1:0]),
        .rdata (tag_rdata)
    );

    ctrt_check #(
        .MAX_CHUNKS(MAX_CHUNKS),
        .CHUNK_PAYLOAD_BYTES(CHUNK_PAYLOAD_BYTES)
    ) u_check (
        .item       (item_reg),
        .offset     (offset_reg),
        .held_valid (held_valid_reg),
        .held       (held_reg),
        .tally      (tally_reg),
        .hit        (hit),
        .res        (chk)
    );

    // sweep writes zero tags; a first arrival writes the live epoch
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = finish && chk.arrive_new;
            ram_waddr = item_reg.chunk_index[AW-1:0];
            ram_wdata = epoch_reg;
        end
    end

    // a restart or a completion retires the current epoch
    assign bump = finish && (chk.restart || chk.done);

    always_comb
    begin
        if (chk.restart)
        begin
            count = 16'd1;
        end
        else if (chk.write_enable)
        begin
            count = chk.tally_inc;
        end
        else if (held_valid_reg)
        begin
            count = tally_reg;
        end
        else
        begin
            count = 16'd0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        epoch_next      = epoch_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        tally_next      = tally_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_addr_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next = S_IDLE;
                    if (chk.restart)
                    begin
                        held_valid_next        = 1'b1;
                        held_next.path_key     = item_reg.path_key;
                        held_next.vertex_total = item_reg.vertex_total;
                        held_next.turn_total   = item_reg.turn_total;
                        held_next.total_chunks = item_reg.total_chunks;
                        held_next.image_bytes  = item_reg.image_bytes;
                        tally_next             = 16'd1;
                    end
                    else if (chk.write_enable)
                    begin
                        tally_next = chk.tally_inc;
                        if (chk.done)
                        begin
                            held_valid_next = 1'b0;
                            tally_next = 16'd0;
                        end
                    end
                    if (bump)
                    begin
                        if (epoch_reg == ctrt_pkg::EPOCH_LAST)
                        begin
                            // wrap: stale tags could alias, sweep first
                            epoch_next = ctrt_pkg::EPOCH_FIRST;
                            state_next = S_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            epoch_reg      <= ctrt_pkg::EPOCH_FIRST;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
            tally_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            epoch_reg      <= epoch_next;
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
            tally_reg      <= tally_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // capture stage: item and (index - 1) * chunk size
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg   <= in_item;
            offset_reg <= OFF_W'(in_item.chunk_index - 16'd1)
                          * OFF_W'(CHUNK_PAYLOAD_BYTES);
        end
        if (finish)
        begin
            out_status_reg   <= chk.status;
            out_accepted_reg <= chk.accepted;
            out_we_reg       <= chk.write_enable;
            out_offset_reg   <= chk.write_enable ? 24'(offset_reg) : 24'd0;
            out_done_reg     <= chk.done;
            out_count_reg    <= count;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'd0, out_count_reg, out_done_reg, out_offset_reg,
                       out_we_reg, out_accepted_reg};

    // a stored payload is the only transfer that writes the image
    a_we_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tuser == ctrt_pkg::ST_STORED && m_tdata[0])
        else $error("write_enable without stored status");

    a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[25:2] == 24'd0)
        else $error("nonzero offset without write");

    a_tally_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid_reg |-> tally_reg == 16'd0)
        else $error("arrival tally nonzero with no manifest");

    a_done_drops: assert property (@(posedge clk) disable iff (!rst_n)
        finish && chk.done |=> !held_valid_reg && m_tvalid)
        else $error("completion did not drop the manifest");

    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !s_tready && epoch_reg == ctrt_pkg::EPOCH_FIRST)
        else $error("chunk accepted during tag sweep");

endmodule
